/* hdl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the i2c master bit engine: command kinds,
// the command beat passed from the front queue to the engine, the result
// beat and the configuration register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // raw action codes on the input port
  localparam logic [3:0] ACT_START    = 4'd1;
  localparam logic [3:0] ACT_STOP     = 4'd2;
  localparam logic [3:0] ACT_WRITE    = 4'd3;
  localparam logic [3:0] ACT_READ_ACK = 4'd4;
  localparam logic [3:0] ACT_READ_RAW = 4'd5;
  localparam logic [3:0] ACT_WAIT_ACK = 4'd6;
  localparam logic [3:0] ACT_ACK      = 4'd7;
  localparam logic [3:0] ACT_NACK     = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_EDGE_HOLD   = 2'd0;
  localparam logic [1:0] REG_HALF_BIT    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_HOLD = 2'd2;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

  // register reset values
  localparam logic [7:0] EDGE_HOLD_RST   = 8'd4;
  localparam logic [7:0] HALF_BIT_RST    = 8'd2;
  localparam logic [7:0] SAMPLE_HOLD_RST = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_ACK,
    CMD_READ_RAW,
    CMD_WAIT_ACK,
    CMD_ACK,
    CMD_NACK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  tx_byte;
    logic        send_ack;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_error;
  } res_t;

endpackage

`default_nettype wire

/* hdl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick beats, decodes the action code into a command kind and holds
// them in a two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front import i2cm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [3:0] action,
  input  wire logic [7:0] tx_byte,
  input  wire logic       send_ack,
  input  wire logic       sda_in,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_take
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    decoded.tx_byte  = tx_byte;
    decoded.send_ack = send_ack;
    decoded.sda_in   = sda_in;
    case (action)
      ACT_START:    decoded.kind = CMD_START;
      ACT_STOP:     decoded.kind = CMD_STOP;
      ACT_WRITE:    decoded.kind = CMD_WRITE;
      ACT_READ_ACK: decoded.kind = CMD_READ_ACK;
      ACT_READ_RAW: decoded.kind = CMD_READ_RAW;
      ACT_WAIT_ACK: decoded.kind = CMD_WAIT_ACK;
      ACT_ACK:      decoded.kind = CMD_ACK;
      ACT_NACK:     decoded.kind = CMD_NACK;
      default:      decoded.kind = CMD_NONE;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= decoded;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one step per command beat. Holds the hold-time registers,
// the phase, segment and bit counters, and drives SCL / SDA per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_take,
  input  wire logic       res_full,
  output logic            res_push,
  output res_t            res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_LO1, PH_WR_HI,
    PH_WR_LO2, PH_RD_LO, PH_RD_SMP, PH_RD_HI, PH_AK_LO, PH_AK_HI,
    PH_WA_REL, PH_WA_CLK, PH_WA_POLL, PH_FIN
  } phase_t;

  logic [7:0] edge_hold;
  logic [7:0] half_bit;
  logic [7:0] sample_hold;
  logic [7:0] ack_timeout;

  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] poll_count, poll_count_next;
  logic       ack_choice, ack_choice_next;
  logic       error_flag, error_flag_next;
  logic [7:0] rx_last, rx_last_next;
  logic       read_acks, read_acks_next;
  logic       scl_out, scl_out_next;
  logic       sda_out, sda_out_next;
  logic       fin_scl, fin_scl_next;
  logic       fin_sda, fin_sda_next;
  logic       done;
  logic       step;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    at_least_one = (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] seg_len(input phase_t p, input logic [7:0] eh,
                                         input logic [7:0] hb,
                                         input logic [7:0] sh);
    case (p)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B:                      seg_len = at_least_one(eh);
      PH_WR_LO1, PH_WR_HI, PH_WR_LO2, PH_RD_LO, PH_AK_LO, PH_AK_HI: seg_len = at_least_one(hb);
      PH_RD_HI:                                                seg_len = at_least_one(sh);
      default:                                                 seg_len = 8'd1;
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign step      = cmd_valid && !res_full;
  assign cmd_take  = step;
  assign res_push  = step;

  always_comb begin
    phase_t     p;
    phase_t     p_run;
    logic [7:0] tc;
    logic       exp;
    logic       bit_tx;
    logic       nak;
    logic [3:0] bc_inc;

    p               = phase;
    tc              = tick_count;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    poll_count_next = poll_count;
    ack_choice_next = ack_choice;
    error_flag_next = error_flag;
    rx_last_next    = rx_last;
    read_acks_next  = read_acks;
    scl_out_next    = scl_out;
    sda_out_next    = sda_out;
    fin_scl_next    = fin_scl;
    fin_sda_next    = fin_sda;
    done            = 1'b0;

    // command intake, only while idle
    if (p == PH_IDLE) begin
      case (cmd.kind)
        CMD_START: p = PH_ST_A;
        CMD_STOP:  p = PH_SP_A;
        CMD_WRITE: begin
          shift_reg_next = cmd.tx_byte;
          bit_count_next = 4'd0;
          p = PH_WR_LO1;
        end
        CMD_READ_ACK, CMD_READ_RAW: begin
          shift_reg_next = 8'd0;
          bit_count_next = 4'd0;
          read_acks_next = (cmd.kind == CMD_READ_ACK);
          if (cmd.kind == CMD_READ_ACK) begin
            ack_choice_next = cmd.send_ack;
          end
          p = PH_RD_LO;
        end
        CMD_WAIT_ACK: begin
          poll_count_next = 8'd0;
          p = PH_WA_REL;
        end
        CMD_ACK: begin
          ack_choice_next = 1'b1;
          p = PH_AK_LO;
        end
        CMD_NACK: begin
          ack_choice_next = 1'b0;
          p = PH_AK_LO;
        end
        default: p = PH_IDLE;
      endcase
      if (p != PH_IDLE) begin
        tc = seg_len(p, edge_hold, half_bit, sample_hold);
      end
    end

    p_run  = p;
    bit_tx = shift_reg_next[7];
    nak    = !ack_choice_next;
    exp    = (tc <= 8'd1);
    bc_inc = bit_count_next + 4'd1;

    case (p)
      PH_IDLE: begin
        p = PH_IDLE;
      end
      PH_ST_A: begin
        {scl_out_next, sda_out_next} = 2'b11;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_ST_B;
      end
      PH_ST_B: begin
        {scl_out_next, sda_out_next} = 2'b10;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) begin
          {fin_scl_next, fin_sda_next} = 2'b00;
          p = PH_FIN;
        end
      end
      PH_SP_A: begin
        {scl_out_next, sda_out_next} = 2'b00;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_SP_B;
      end
      PH_SP_B: begin
        {scl_out_next, sda_out_next} = 2'b11;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) begin
          {fin_scl_next, fin_sda_next} = 2'b11;
          p = PH_FIN;
        end
      end
      PH_WR_LO1: begin
        {scl_out_next, sda_out_next} = {1'b0, bit_tx};
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_WR_HI;
      end
      PH_WR_HI: begin
        {scl_out_next, sda_out_next} = {1'b1, bit_tx};
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_WR_LO2;
      end
      PH_WR_LO2: begin
        {scl_out_next, sda_out_next} = {1'b0, bit_tx};
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) begin
          shift_reg_next = {shift_reg_next[6:0], 1'b0};
          bit_count_next = bc_inc;
          if (bc_inc >= 4'd8) begin
            {fin_scl_next, fin_sda_next} = {1'b0, bit_tx};
            p = PH_FIN;
          end else begin
            p = PH_WR_LO1;
          end
        end
      end
      PH_RD_LO: begin
        {scl_out_next, sda_out_next} = 2'b01;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_RD_SMP;
      end
      PH_RD_SMP: begin
        {scl_out_next, sda_out_next} = 2'b11;
        shift_reg_next = {shift_reg_next[6:0], cmd.sda_in};
        p = PH_RD_HI;
      end
      PH_RD_HI: begin
        {scl_out_next, sda_out_next} = 2'b11;
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) begin
          bit_count_next = bc_inc;
          if (bc_inc >= 4'd8) begin
            rx_last_next = shift_reg_next;
            if (read_acks_next) begin
              p = PH_AK_LO;
            end else begin
              {fin_scl_next, fin_sda_next} = 2'b11;
              p = PH_FIN;
            end
          end else begin
            p = PH_RD_LO;
          end
        end
      end
      PH_AK_LO: begin
        {scl_out_next, sda_out_next} = {1'b0, nak};
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) p = PH_AK_HI;
      end
      PH_AK_HI: begin
        {scl_out_next, sda_out_next} = {1'b1, nak};
        tc = exp ? 8'd0 : tc - 8'd1;
        if (exp) begin
          {fin_scl_next, fin_sda_next} = {1'b0, nak};
          p = PH_FIN;
        end
      end
      PH_WA_REL: begin
        sda_out_next = 1'b1;
        p = PH_WA_CLK;
      end
      PH_WA_CLK: begin
        {scl_out_next, sda_out_next} = 2'b11;
        p = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        {scl_out_next, sda_out_next} = 2'b11;
        if (!cmd.sda_in) begin
          error_flag_next = 1'b0;
          {fin_scl_next, fin_sda_next} = 2'b01;
          p = PH_FIN;
        end else if (poll_count_next >= ack_timeout) begin
          // timed out: flag it and run a full stop
          error_flag_next = 1'b1;
          p = PH_SP_A;
        end else begin
          poll_count_next = poll_count_next + 8'd1;
        end
      end
      PH_FIN: begin
        {scl_out_next, sda_out_next} = {fin_scl_next, fin_sda_next};
        done = 1'b1;
        p  = PH_IDLE;
        tc = 8'd0;
      end
      default: p = PH_IDLE;
    endcase

    // a new segment reloads its length
    if (p != p_run) begin
      tc = (p == PH_IDLE) ? 8'd0 : seg_len(p, edge_hold, half_bit, sample_hold);
    end
    phase_next      = p;
    tick_count_next = tc;
  end

  assign res.scl_level   = scl_out_next;
  assign res.sda_release = sda_out_next;
  assign res.busy_res    = (phase_next != PH_IDLE);
  assign res.done_res    = done;
  assign res.rx_byte     = rx_last_next;
  assign res.ack_error   = error_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_hold   <= EDGE_HOLD_RST;
      half_bit    <= HALF_BIT_RST;
      sample_hold <= SAMPLE_HOLD_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
      phase       <= PH_IDLE;
      tick_count  <= 8'd0;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      poll_count  <= 8'd0;
      ack_choice  <= 1'b0;
      error_flag  <= 1'b0;
      rx_last     <= 8'd0;
      read_acks   <= 1'b0;
      scl_out     <= 1'b1;
      sda_out     <= 1'b1;
      fin_scl     <= 1'b1;
      fin_sda     <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EDGE_HOLD:   edge_hold   <= cfg_data;
          REG_HALF_BIT:    half_bit    <= cfg_data;
          REG_SAMPLE_HOLD: sample_hold <= cfg_data;
          REG_ACK_TIMEOUT: ack_timeout <= cfg_data;
          default:         edge_hold   <= edge_hold;
        endcase
      end
      if (step) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        bit_count  <= bit_count_next;
        shift_reg  <= shift_reg_next;
        poll_count <= poll_count_next;
        ack_choice <= ack_choice_next;
        error_flag <= error_flag_next;
        rx_last    <= rx_last_next;
        read_acks  <= read_acks_next;
        scl_out    <= scl_out_next;
        sda_out    <= sda_out_next;
        fin_scl    <= fin_scl_next;
        fin_sda    <= fin_sda_next;
      end
    end
  end

  // the closing tick of a command always reports done and not busy
  assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_FIN) |-> (res.done_res && !res.busy_res))
    else $error("final tick without done");

  // the sequencer only moves on a command beat
  assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase))
    else $error("phase moved without a beat");

  // busy in a result matches the phase left behind
  assert property (@(posedge clk) disable iff (rst)
    step |=> ((phase == PH_IDLE) == !$past(res.busy_res)))
    else $error("busy disagrees with phase");

endmodule

`default_nettype wire

/* hdl/i2cm_out_queue.sv */
// ----------------------------------------------------------------------------
// i2cm_out_queue
// Two-entry result queue between the engine and the result port, so the
// engine keeps stepping while the receiver holds off, until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_out_queue import i2cm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_push,
  input  res_t      res_in,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_out
);

  res_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = slots[rptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= res_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bus-primitive engine, one timebase tick per input beat.
//
// Input channel (push / full): each beat is one tick carrying action,
// tx_byte, send_ack and the sampled sda_in. An action is only taken while
// the engine is idle; during a command the action field is ignored.
// Result channel (empty / pop): exactly one result beat per input beat,
// in order: SCL level, SDA release, busy, done pulse, last received byte
// and the ack error flag.
// Config channel (cfg_valid / cfg_ready): cfg_index 0..3 selects edge hold,
// half bit, sample hold, ack timeout; cfg_ready is always high.
// A result reaches the result ports through the input queue slot, then the
// result queue slot. Throughput is one beat per cycle unless the result
// queue is full or the input queue is empty; one sequencer step per beat.
// Two-entry queues on both sides let input and result sides stall apart.
// Reset: registers return to their defaults, lines rest released high, and
// both queues empty. A stalled receiver fills the result queue, after which
// the input queue fills and full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine import i2cm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [3:0] action,
  input  wire logic [7:0] tx_byte,
  input  wire logic       send_ack,
  input  wire logic       sda_in,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_level,
  output logic            sda_release,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_error,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  res_t res_eng;
  res_t res_q;
  logic res_push;
  logic res_full;

  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .tx_byte   (tx_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_eng)
  );

  i2cm_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_eng),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_q)
  );

  assign scl_level   = res_q.scl_level;
  assign sda_release = res_q.sda_release;
  assign busy_res    = res_q.busy_res;
  assign done_res    = res_q.done_res;
  assign rx_byte     = res_q.rx_byte;
  assign ack_error   = res_q.ack_error;

endmodule

`default_nettype wire

/* tb/i2cm_bus_checker.sv */
// ----------------------------------------------------------------------------
// i2cm_bus_checker
// Watches the tick, result and register channels of the i2c master bit
// engine. Every accepted tick runs through a cycle-true copy of the bus
// sequencer, and every accepted result beat is compared field by field with
// the oldest predicted line state. Exports the failure count, the number of
// predictions still waiting and the number of commands the engine took.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_bus_checker import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [3:0] action,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  input  logic       empty,
  input  logic       pop,
  input  logic       scl_level,
  input  logic       sda_release,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] rx_byte,
  input  logic       ack_error,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         outstanding,
  output int         cmd_count
);

  typedef enum logic [4:0] {
    SEG_IDLE,
    SEG_START_HI,
    SEG_START_LO,
    SEG_STOP_LO,
    SEG_STOP_HI,
    SEG_WR_LO1,
    SEG_WR_HI,
    SEG_WR_LO2,
    SEG_RD_LO,
    SEG_RD_SAMPLE,
    SEG_RD_HI,
    SEG_ACK_LO,
    SEG_ACK_HI,
    SEG_WA_RELEASE,
    SEG_WA_CLOCK,
    SEG_WA_POLL,
    SEG_FINAL
  } seg_t;

  seg_t       seg;
  logic [7:0] ticks_left;
  logic [3:0] bits_done;
  logic [7:0] shreg;
  logic [7:0] polls;
  logic       ack_sel;
  logic       err_flag;
  logic [7:0] rx_hold;
  logic       read_with_ack;
  logic       scl_q;
  logic       sda_q;
  logic       fin_scl;
  logic       fin_sda;

  logic [7:0] edge_hold;
  logic [7:0] half_bit;
  logic [7:0] sample_hold;
  logic [7:0] ack_limit;

  res_t       bus_levels_q[$];
  int         takes;

  task automatic enter_seg(input seg_t s);
    logic [7:0] n;
    case (s)
      SEG_START_HI, SEG_START_LO, SEG_STOP_LO, SEG_STOP_HI: n = edge_hold;
      SEG_WR_LO1, SEG_WR_HI, SEG_WR_LO2, SEG_RD_LO, SEG_ACK_LO, SEG_ACK_HI: n = half_bit;
      SEG_RD_HI: n = sample_hold;
      default: n = 8'd1;
    endcase
    seg = s;
    // a zero hold still lasts one tick
    ticks_left = (n == 8'd0) ? 8'd1 : n;
  endtask

  task automatic finish_cmd(input logic s, input logic d);
    fin_scl = s;
    fin_sda = d;
    seg = SEG_FINAL;
    ticks_left = 8'd1;
  endtask

  function automatic logic seg_expired();
    if (ticks_left <= 8'd1) begin
      ticks_left = 8'd0;
      return 1'b1;
    end
    ticks_left = ticks_left - 8'd1;
    return 1'b0;
  endfunction

  task automatic drive_lines(input logic s, input logic d);
    scl_q = s;
    sda_q = d;
  endtask

  // one timebase tick of the sequencer, returns the line state after it
  task automatic advance_bus_tick(input logic [3:0] act, input logic [7:0] tx,
                                  input logic sack, input logic sda,
                                  output res_t r);
    logic data_bit;
    logic nak;
    logic done;
    done = 1'b0;
    if (seg == SEG_IDLE) begin
      case (act)
        ACT_START: enter_seg(SEG_START_HI);
        ACT_STOP: enter_seg(SEG_STOP_LO);
        ACT_WRITE: begin
          shreg = tx;
          bits_done = 4'd0;
          enter_seg(SEG_WR_LO1);
        end
        ACT_READ_ACK, ACT_READ_RAW: begin
          shreg = 8'd0;
          bits_done = 4'd0;
          read_with_ack = (act == ACT_READ_ACK);
          if (act == ACT_READ_ACK) ack_sel = sack;
          enter_seg(SEG_RD_LO);
        end
        ACT_WAIT_ACK: begin
          polls = 8'd0;
          enter_seg(SEG_WA_RELEASE);
        end
        ACT_ACK: begin
          ack_sel = 1'b1;
          enter_seg(SEG_ACK_LO);
        end
        ACT_NACK: begin
          ack_sel = 1'b0;
          enter_seg(SEG_ACK_LO);
        end
        default: ;
      endcase
      if (seg != SEG_IDLE) takes++;
    end

    data_bit = shreg[7];
    nak = ~ack_sel;
    if (seg != SEG_IDLE) begin
      case (seg)
        SEG_START_HI: begin
          drive_lines(1'b1, 1'b1);
          if (seg_expired()) enter_seg(SEG_START_LO);
        end
        SEG_START_LO: begin
          drive_lines(1'b1, 1'b0);
          if (seg_expired()) finish_cmd(1'b0, 1'b0);
        end
        SEG_STOP_LO: begin
          drive_lines(1'b0, 1'b0);
          if (seg_expired()) enter_seg(SEG_STOP_HI);
        end
        SEG_STOP_HI: begin
          drive_lines(1'b1, 1'b1);
          if (seg_expired()) finish_cmd(1'b1, 1'b1);
        end
        SEG_WR_LO1: begin
          drive_lines(1'b0, data_bit);
          if (seg_expired()) enter_seg(SEG_WR_HI);
        end
        SEG_WR_HI: begin
          drive_lines(1'b1, data_bit);
          if (seg_expired()) enter_seg(SEG_WR_LO2);
        end
        SEG_WR_LO2: begin
          drive_lines(1'b0, data_bit);
          if (seg_expired()) begin
            shreg = {shreg[6:0], 1'b0};
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'd8) finish_cmd(1'b0, data_bit);
            else enter_seg(SEG_WR_LO1);
          end
        end
        SEG_RD_LO: begin
          drive_lines(1'b0, 1'b1);
          if (seg_expired()) enter_seg(SEG_RD_SAMPLE);
        end
        SEG_RD_SAMPLE: begin
          drive_lines(1'b1, 1'b1);
          shreg = {shreg[6:0], sda};
          enter_seg(SEG_RD_HI);
        end
        SEG_RD_HI: begin
          drive_lines(1'b1, 1'b1);
          if (seg_expired()) begin
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'd8) begin
              rx_hold = shreg;
              if (read_with_ack) enter_seg(SEG_ACK_LO);
              else finish_cmd(1'b1, 1'b1);
            end else begin
              enter_seg(SEG_RD_LO);
            end
          end
        end
        SEG_ACK_LO: begin
          drive_lines(1'b0, nak);
          if (seg_expired()) enter_seg(SEG_ACK_HI);
        end
        SEG_ACK_HI: begin
          drive_lines(1'b1, nak);
          if (seg_expired()) finish_cmd(1'b0, nak);
        end
        SEG_WA_RELEASE: begin
          drive_lines(scl_q, 1'b1);
          enter_seg(SEG_WA_CLOCK);
        end
        SEG_WA_CLOCK: begin
          drive_lines(1'b1, 1'b1);
          enter_seg(SEG_WA_POLL);
        end
        SEG_WA_POLL: begin
          drive_lines(1'b1, 1'b1);
          if (sda == 1'b0) begin
            err_flag = 1'b0;
            finish_cmd(1'b0, 1'b1);
          end else if (polls >= ack_limit) begin
            // timed out, fall into a full stop sequence
            err_flag = 1'b1;
            enter_seg(SEG_STOP_LO);
          end else begin
            polls = polls + 8'd1;
          end
        end
        SEG_FINAL: begin
          drive_lines(fin_scl, fin_sda);
          done = 1'b1;
          seg = SEG_IDLE;
          ticks_left = 8'd0;
        end
        default: seg = SEG_IDLE;
      endcase
    end

    r.scl_level = scl_q;
    r.sda_release = sda_q;
    r.busy_res = (seg != SEG_IDLE);
    r.done_res = done;
    r.rx_byte = rx_hold;
    r.ack_error = err_flag;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      seg = SEG_IDLE;
      ticks_left = 8'd0;
      bits_done = 4'd0;
      shreg = 8'd0;
      polls = 8'd0;
      ack_sel = 1'b0;
      err_flag = 1'b0;
      rx_hold = 8'd0;
      read_with_ack = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      fin_scl = 1'b1;
      fin_sda = 1'b1;
      edge_hold = EDGE_HOLD_RST;
      half_bit = HALF_BIT_RST;
      sample_hold = SAMPLE_HOLD_RST;
      ack_limit = ACK_TIMEOUT_RST;
      bus_levels_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EDGE_HOLD: edge_hold = cfg_data;
          REG_HALF_BIT: half_bit = cfg_data;
          REG_SAMPLE_HOLD: sample_hold = cfg_data;
          REG_ACK_TIMEOUT: ack_limit = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        advance_bus_tick(action, tx_byte, send_ack, sda_in, want);
        bus_levels_q.push_back(want);
      end
      if (pop && !empty) begin
        if (bus_levels_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got scl %b sda %b rx %0h",
                   $time, scl_level, sda_release, rx_byte);
          errors++;
        end else begin
          want = bus_levels_q.pop_front();
          compare_field("scl_level", {7'd0, want.scl_level}, {7'd0, scl_level});
          compare_field("sda_release", {7'd0, want.sda_release}, {7'd0, sda_release});
          compare_field("busy_res", {7'd0, want.busy_res}, {7'd0, busy_res});
          compare_field("done_res", {7'd0, want.done_res}, {7'd0, done_res});
          compare_field("rx_byte", want.rx_byte, rx_byte);
          compare_field("ack_error", {7'd0, want.ack_error}, {7'd0, ack_error});
        end
      end
    end
    outstanding <= bus_levels_q.size();
    cmd_count <= takes;
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the i2c master bit engine. Sends timebase ticks that carry
// directed commands, then randomized bus transactions (start, address,
// ack waits, data writes and reads, stop) with stray commands mixed in,
// under several register settings and random idling on both sides,
// including one long result stall. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import i2cm_pkg::*; ();

  localparam logic [3:0] ACT_IDLE       = 4'd0;
  localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRESSURE_CYCLES = 400;
  localparam int RANDOM_PHASES = 3;
  localparam int TICK_QUOTA = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [3:0] action = ACT_IDLE;
  logic [7:0] tx_byte = 8'd0;
  logic       send_ack = 1'b0;
  logic       sda_in = 1'b1;
  logic       empty;
  logic       pop = 1'b0;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_EDGE_HOLD;
  logic [7:0] cfg_data = 8'd0;

  int errors;
  int outstanding;
  int cmd_count;
  int cycles = 0;
  int ticks_sent = 0;

  int send_gap_max = 12;
  int recv_gap_max = 12;
  int sda_low_pct = 50;
  logic pressure_req = 1'b0;
  logic pressure_done = 1'b0;

  i2c_master_bit_engine uut (.*);

  i2cm_bus_checker checker_i (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [3:0] rand_act();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // result side: random stalls per beat, one long hold-off on request
  initial begin : result_sink
    int g;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        pop <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
        pop <= 1'b1;
      end else if (!pop) begin
        pop <= 1'b1;
      end else if (!empty) begin
        g = $urandom_range(0, recv_gap_max);
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g) @(posedge clk);
          pop <= 1'b1;
        end
      end
    end
  end

  task automatic send_tick(input logic [3:0] act, input logic [7:0] tx, input logic sack);
    int gap;
    action <= act;
    tx_byte <= tx;
    send_ack <= sack;
    sda_in <= ($urandom_range(0, 99) < sda_low_pct) ? 1'b0 : 1'b1;
    push <= 1'b1;
    do @(posedge clk); while (full);
    ticks_sent++;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // keep offering a command until the engine takes it; ticks spent while
  // it is busy carry the same command and are ignored
  task automatic issue(input logic [3:0] act, input logic [7:0] tx, input logic sack);
    int start_count;
    start_count = cmd_count;
    send_tick(act, tx, sack);
    if (act != ACT_IDLE && act <= ACT_NACK) begin
      while (cmd_count == start_count) send_tick(act, tx, sack);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] e, input logic [7:0] h,
                            input logic [7:0] s, input logic [7:0] t);
    settle();
    write_reg(REG_EDGE_HOLD, e);
    write_reg(REG_HALF_BIT, h);
    write_reg(REG_SAMPLE_HOLD, s);
    write_reg(REG_ACK_TIMEOUT, t);
  endtask

  task automatic transaction();
    logic [7:0] addr;
    int n;
    int i;
    addr = rand_byte();
    n = $urandom_range(0, 3);
    case ($urandom_range(0, 4))
      0: sda_low_pct = 0;
      1: sda_low_pct = 10;
      2: sda_low_pct = 50;
      3: sda_low_pct = 90;
      default: sda_low_pct = 100;
    endcase
    if ($urandom_range(0, 9) == 0)
      issue(rand_act(), rand_byte(), rand_bit());
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 20)) issue(ACT_IDLE, rand_byte(), rand_bit());
    issue(ACT_START, rand_byte(), rand_bit());
    issue(ACT_WRITE, addr, rand_bit());
    issue(ACT_WAIT_ACK, rand_byte(), rand_bit());
    for (i = 0; i < n; i++) begin
      // occasional stray command inside the transfer
      if ($urandom_range(0, 9) == 0)
        issue(rand_act(), rand_byte(), rand_bit());
      if (!addr[0]) begin
        issue(ACT_WRITE, rand_byte(), rand_bit());
        issue(ACT_WAIT_ACK, rand_byte(), rand_bit());
      end else if ($urandom_range(0, 3) == 0) begin
        issue(ACT_READ_RAW, rand_byte(), rand_bit());
        issue((i == n - 1) ? ACT_NACK : ACT_ACK, rand_byte(), rand_bit());
      end else begin
        // last byte of a read gets a nack
        issue(ACT_READ_ACK, rand_byte(), (i != n - 1));
      end
    end
    if ($urandom_range(0, 9) != 0)
      issue(ACT_STOP, rand_byte(), rand_bit());
  endtask

  initial begin : stimulus
    int p;
    int base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset, idle and unknown actions
    issue(ACT_IDLE, 8'h00, 1'b0);
    issue(ACT_IDLE, 8'hFF, 1'b1);
    issue(ACT_UNKNOWN_HI, 8'hFF, 1'b1);
    issue(ACT_UNKNOWN_LO, 8'h00, 1'b0);
    issue(ACT_START, 8'h00, 1'b0);
    issue(ACT_WRITE, 8'hA5, 1'b0);
    sda_low_pct = 100;
    issue(ACT_WAIT_ACK, 8'h00, 1'b0);
    issue(ACT_STOP, 8'h00, 1'b0);

    // minimum holds, every command
    set_config(8'd1, 8'd1, 8'd1, 8'd1);
    sda_low_pct = 50;
    issue(ACT_START, 8'h00, 1'b0);
    issue(ACT_WRITE, 8'hFF, 1'b0);
    issue(ACT_WRITE, 8'h00, 1'b1);
    sda_low_pct = 100;
    issue(ACT_WAIT_ACK, 8'h00, 1'b0);
    issue(ACT_READ_ACK, 8'h00, 1'b1);
    sda_low_pct = 0;
    issue(ACT_WAIT_ACK, 8'h00, 1'b0);
    issue(ACT_READ_ACK, 8'hFF, 1'b0);
    sda_low_pct = 50;
    issue(ACT_READ_RAW, 8'h00, 1'b1);
    issue(ACT_ACK, 8'h00, 1'b0);
    issue(ACT_NACK, 8'h00, 1'b1);
    issue(ACT_STOP, 8'h00, 1'b0);

    // zero holds count as one tick, zero timeout fails on the first high poll
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    issue(ACT_START, 8'h00, 1'b0);
    issue(ACT_WRITE, 8'h5A, 1'b0);
    sda_low_pct = 0;
    issue(ACT_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 50;
    issue(ACT_READ_RAW, 8'h00, 1'b0);
    issue(ACT_READ_ACK, 8'h00, 1'b1);
    issue(ACT_STOP, 8'h00, 1'b0);

    // register change while a write is in flight
    set_config(8'd1, 8'd3, 8'd1, 8'd1);
    issue(ACT_WRITE, 8'hC3, 1'b0);
    repeat (4) issue(ACT_IDLE, 8'h00, 1'b0);
    settle();
    write_reg(REG_HALF_BIT, 8'd1);
    repeat (3) issue(ACT_IDLE, 8'h00, 1'b0);
    issue(ACT_STOP, 8'h00, 1'b0);

    // longest ack wait: timeout at its maximum with the line held high
    set_config(8'd1, 8'd1, 8'd1, 8'd255);
    sda_low_pct = 0;
    issue(ACT_WAIT_ACK, 8'h00, 1'b0);
    issue(ACT_STOP, 8'h00, 1'b0);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        set_config(8'd1, 8'd1, 8'd1, 8'd1);
      else
        set_config(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                   8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)));
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      if (p == 1) begin
        send_gap_max = 2;
        pressure_req = 1'b1;
      end
      base = ticks_sent;
      while (ticks_sent - base < TICK_QUOTA) transaction();
    end

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_engine.sv
hdl/i2cm_out_queue.sv
hdl/i2c_master_bit_engine.sv
tb/i2cm_bus_checker.sv
tb/tb.sv
